/* hdl/rdc_pkg.sv */
// Shared types and constants for the rank and duplicate check unit.
package rdc_pkg;

    localparam int unsigned MaxItemsDefault = 64;
    localparam int unsigned ValueWidth      = 32;
    localparam int unsigned RankWidth       = 6;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_DUP,
        STATUS_OVF
    } status_t;

    // Beat travelling down the cell chain
    typedef struct packed {
        logic                  valid;
        logic [ValueWidth-1:0] value;
        logic [RankWidth-1:0]  acc;     // number of stored values below this one
        logic                  dup;     // an equal value was met
        logic                  stored;  // taken by an empty cell
        logic                  last;    // final beat of the run
    } token_t;

    // Control from the sequencer to every cell
    typedef struct packed {
        logic shift;   // move occupancy and rank one cell towards the head
        logic clear;   // drop all stored entries
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_ERR,
        ST_READ
    } state_t;

endpackage

/* hdl/rdc_cell.sv */
// One cell of the chain: holds one value and its rank, passes the beat on.
module rdc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rdc_pkg::token_t             tok_i,
    output rdc_pkg::token_t             tok_o,
    input  rdc_pkg::cell_ctrl_t         ctrl_i,
    input  logic                        occ_right_i,
    input  logic [rdc_pkg::RankWidth-1:0] rank_right_i,
    output logic                        occ_o,
    output logic [rdc_pkg::RankWidth-1:0] rank_o
);

    rdc_pkg::token_t tok_reg, tok_next;
    logic            occ_reg, occ_next;
    logic [rdc_pkg::ValueWidth-1:0] val_reg, val_next;
    logic [rdc_pkg::RankWidth-1:0]  rank_reg, rank_next;

    // Clear or shift on control, else compare the passing beat with the stored value, or take it if empty
    always_comb begin
        tok_next  = tok_i;
        occ_next  = occ_reg;
        val_next  = val_reg;
        rank_next = rank_reg;
        if (ctrl_i.clear) begin
            occ_next = 1'b0;
        end else if (ctrl_i.shift) begin
            occ_next  = occ_right_i;
            rank_next = rank_right_i;
        end else if (tok_i.valid && !tok_i.stored) begin
            if (!occ_reg) begin
                occ_next        = 1'b1;
                val_next        = tok_i.value;
                rank_next       = tok_i.acc;
                tok_next.stored = 1'b1;
            end else if (val_reg == tok_i.value) begin
                tok_next.dup = 1'b1;
            end else if ($signed(val_reg) > $signed(tok_i.value)) begin
                rank_next = rank_reg + 1'b1;
            end else begin
                tok_next.acc = tok_i.acc + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
            occ_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            occ_reg <= occ_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        rank_reg <= rank_next;
    end

    assign tok_o  = tok_reg;
    assign occ_o  = occ_reg;
    assign rank_o = rank_reg;

endmodule

/* hdl/rank_and_duplicate_check_unit.sv */
// Top level of the rank and duplicate check unit: cell chain and result sequencer.
//
// Values stream in one beat per cycle while a run is open; each beat walks down a
// chain of MAX_ITEMS cells, one cell per cycle, comparing itself with the value held
// in every occupied cell and settling in the first empty one. After the beat marked
// tlast is taken the input stalls until that beat has left the chain, then the
// results follow: one beat on error, else one beat per stored value in arrival
// order, at one per cycle while m_tready is high. The next run opens after the
// final result beat is loaded into the output register.
module rank_and_duplicate_check_unit #(
    parameter int unsigned MAX_ITEMS = rdc_pkg::MaxItemsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic        s_tlast,    // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [5:0] rank, [7:6] zero
    output logic [2:0]  m_tuser,    // [1:0] status, [2] already_sorted
    output logic        m_tlast     // last_result
);

    localparam int unsigned RW = rdc_pkg::RankWidth;

    rdc_pkg::token_t     tok_w  [MAX_ITEMS+1];
    logic                occ_w  [MAX_ITEMS+1];
    logic [RW-1:0]       rank_w [MAX_ITEMS+1];
    rdc_pkg::cell_ctrl_t ctrl;

    rdc_pkg::state_t state_reg, state_next;
    logic            dup_reg, dup_next;
    logic            ovf_reg, ovf_next;
    logic            sorted_reg, sorted_next;
    logic            first_reg, first_next;
    logic [RW-1:0]   prev_reg, prev_next;

    logic            m_valid_reg, m_valid_next;
    logic [RW-1:0]   m_rank_reg, m_rank_next;
    logic [1:0]      m_status_reg, m_status_next;
    logic            m_sorted_reg, m_sorted_next;
    logic            m_last_reg, m_last_next;

    logic accept;
    logic out_free;
    logic read_last;
    logic read_ok;
    rdc_pkg::token_t tok_end;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign tok_end  = tok_w[MAX_ITEMS];

    // Beat entering the head of the chain
    assign tok_w[0] = {accept, s_tdata, {RW{1'b0}}, 1'b0, 1'b0, s_tlast};

    assign occ_w[MAX_ITEMS]  = 1'b0;
    assign rank_w[MAX_ITEMS] = '0;

    // Cell chain
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        rdc_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .tok_i        (tok_w[i]),
            .tok_o        (tok_w[i+1]),
            .ctrl_i       (ctrl),
            .occ_right_i  (occ_w[i+1]),
            .rank_right_i (rank_w[i+1]),
            .occ_o        (occ_w[i]),
            .rank_o       (rank_w[i])
        );
    end

    assign read_last = !occ_w[1];
    assign read_ok   = first_reg || (prev_reg < rank_w[0]);

    // Sequencer: next state and outputs
    always_comb begin
        state_next    = state_reg;
        dup_next      = dup_reg;
        ovf_next      = ovf_reg;
        sorted_next   = sorted_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_rank_next   = m_rank_reg;
        m_status_next = m_status_reg;
        m_sorted_next = m_sorted_reg;
        m_last_next   = m_last_reg;
        ctrl          = '0;
        s_tready      = (state_reg == rdc_pkg::ST_RUN);

        // sticky errors from beats leaving the chain
        if (tok_end.valid) begin
            dup_next = dup_reg | tok_end.dup;
            ovf_next = ovf_reg | !tok_end.stored;
        end

        unique case (state_reg)
            rdc_pkg::ST_RUN: begin
                if (accept && s_tlast) begin
                    state_next = rdc_pkg::ST_DRAIN;
                end
            end
            rdc_pkg::ST_DRAIN: begin
                if (tok_end.valid && tok_end.last) begin
                    if (dup_next || ovf_next) begin
                        state_next = rdc_pkg::ST_ERR;
                    end else begin
                        state_next  = rdc_pkg::ST_READ;
                        sorted_next = 1'b1;
                        first_next  = 1'b1;
                    end
                end
            end
            rdc_pkg::ST_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_rank_next   = '0;
                    m_status_next = ovf_reg ? rdc_pkg::STATUS_OVF : rdc_pkg::STATUS_DUP;
                    m_sorted_next = 1'b0;
                    m_last_next   = 1'b1;
                    ctrl.clear    = 1'b1;
                    dup_next      = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = rdc_pkg::ST_RUN;
                end
            end
            rdc_pkg::ST_READ: begin
                if (out_free) begin
                    sorted_next   = sorted_reg & read_ok;
                    m_valid_next  = 1'b1;
                    m_rank_next   = rank_w[0];
                    m_status_next = rdc_pkg::STATUS_OK;
                    m_sorted_next = read_last & sorted_reg & read_ok;
                    m_last_next   = read_last;
                    ctrl.shift    = 1'b1;
                    prev_next     = rank_w[0];
                    first_next    = 1'b0;
                    if (read_last) begin
                        dup_next   = 1'b0;
                        ovf_next   = 1'b0;
                        state_next = rdc_pkg::ST_RUN;
                    end
                end
            end
            default: begin
                state_next = rdc_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rdc_pkg::ST_RUN;
            dup_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            sorted_reg  <= 1'b1;
            first_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dup_reg     <= dup_next;
            ovf_reg     <= ovf_next;
            sorted_reg  <= sorted_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output beat payload
    always_ff @(posedge aclk) begin
        prev_reg     <= prev_next;
        m_rank_reg   <= m_rank_next;
        m_status_reg <= m_status_next;
        m_sorted_reg <= m_sorted_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_rank_reg};
    assign m_tuser  = {m_sorted_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule
